@@ sv/kyg_pkg.sv @@
// Shared types, widths and codes of the Knuth-Yao Gaussian sampler.
package kyg_pkg;

  // Default geometry of the probability matrix.
  localparam int ROWS_DEF = 64;
  localparam int COLS_DEF = 64;

  // Field and register widths.
  localparam int ROW_IDX_W = 6;
  localparam int ROW_BITS_W = 64;
  localparam int RND_W = 64;
  localparam int VB_W = 6;
  localparam int CENTER_W = 10;
  localparam int NROWS_W = 7;
  localparam int SAMPLE_W = 11;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 10;

  // Register reset values.
  localparam logic [VB_W-1:0] VB_RST = 6'd52;
  localparam logic signed [CENTER_W-1:0] CENTER_RST = 10'sd0;
  localparam logic [NROWS_W-1:0] NROWS_RST = 7'd64;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_VALUE_BOUND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = 2'd2;

  // Opcodes of an input beat.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // Input beat.
  typedef struct packed {
    logic opcode;
    logic [ROW_IDX_W-1:0] row_index;
    logic [ROW_BITS_W-1:0] row_bits;
    logic [RND_W-1:0] random_bits;
    logic sign_bit;
  } in_beat_t;

  // Result beat.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_value;
    logic column_found;
  } out_beat_t;

endpackage

@@ sv/knuth_yao_gaussian_sampler.sv @@
// Top level of the constant-time Knuth-Yao discrete Gaussian sampler.
//
// Input channel (in_valid/in_ready/in_data) carries two kinds of beat. A load
// beat writes one row of the probability matrix into the matrix RAM. A sample
// beat walks rows 0 to rows_in_use-1 of the matrix, with rows_in_use
// saturated to the matrix depth, one row per cycle, and yields one result
// beat on the out channel. One RAM read is issued per row, the registered
// read data of the last row is stepped in the drain state, and the signed
// result is formed in the done state. With no rows in use the sampler goes
// straight to the done state. The input opens again as the result is
// registered, so a new sample is accepted only once the row walk of the last
// one through the single RAM read port is done.
// The input is ready again once the result sits in the output register, so
// the next beat is accepted while that result waits to be taken. If the
// receiver stalls and the output register is still full when the next
// result is done, the sampler holds that result and keeps in_ready low.
// Reset (rst_n low at a clock edge) restores the configuration registers and
// clears the control state; the matrix RAM keeps no reset and every row used
// by a sample must be loaded first. Configuration writes on the cfg port take
// effect at once; the user makes them only while idle, as the block does not check.
module knuth_yao_gaussian_sampler #(
  parameter int ROWS = kyg_pkg::ROWS_DEF,
  parameter int COLS = kyg_pkg::COLS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  kyg_pkg::in_beat_t                    in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output kyg_pkg::out_beat_t                   out_data,
  input  logic                                 cfg_we,
  input  logic [kyg_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [kyg_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
  import kyg_pkg::*;

  localparam int RW = $clog2(ROWS);
  localparam int CW = $clog2(COLS);
  localparam int CNT_W = $clog2(COLS + 1);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_DRAIN, S_DONE} state_t;

  state_t state_r;

  // Configuration registers.
  logic [VB_W-1:0]            vb_r;
  logic signed [CENTER_W-1:0] center_r;
  logic [NROWS_W-1:0]         nrows_cfg_r;

  // Sample context and walk state.
  logic [RND_W-1:0] rnd_r;
  logic             sign_r;
  logic [RW-1:0]    row_r;
  logic [RW-1:0]    pipe_row_r;
  logic             pipe_v_r;
  logic [ROWS-1:0]  dist_r;
  logic             hit_r;
  logic [CW-1:0]    hitcol_r;
  logic             out_valid_r;
  out_beat_t        out_data_r;

  // Next values of the walk state.
  logic [ROWS-1:0] dist_nxt;
  logic            hit_nxt;
  logic [CW-1:0]   hitcol_nxt;

  logic               accept;
  logic               ram_we;
  logic               ram_re;
  logic [COLS-1:0]    ram_rdata;
  logic [NROWS_W-1:0] nrows;
  logic [NROWS_W-1:0] nrows_m1;
  logic               last_row;
  logic               out_free;
  logic [COLS-1:0]    col_mask;
  logic [COLS-1:0]    row_m;
  logic [COLS-1:0]    sel;
  logic [ROWS-1:0]    dist_dbl;
  logic [CW-1:0]      hc;
  logic [CNT_W-1:0]   cnt_before [COLS];
  logic [CNT_W-1:0]   pc;
  logic signed [11:0] val_w;
  logic signed [11:0] val_s;

  assign in_ready = (state_r == S_IDLE);
  assign accept = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data = out_data_r;
  assign out_free = !out_valid_r || out_ready;

  // Rows walked per sample, saturated to the matrix depth.
  assign nrows = (nrows_cfg_r > NROWS_W'(ROWS)) ? NROWS_W'(ROWS) : nrows_cfg_r;
  assign nrows_m1 = nrows - NROWS_W'(1);
  assign last_row = ({{(NROWS_W - RW){1'b0}}, row_r} == nrows_m1);

  // Matrix RAM: loads write in idle, the walk reads one row per cycle.
  assign ram_we = accept && (in_data.opcode == OP_LOAD) &&
                  ({1'b0, in_data.row_index} < (ROW_IDX_W + 1)'(ROWS));
  assign ram_re = (state_r == S_READ);

  kyg_ram #(
    .WIDTH (COLS),
    .DEPTH (ROWS)
  ) u_matrix (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_data.row_index[RW-1:0]),
    .wdata (in_data.row_bits[COLS-1:0]),
    .re    (ram_re),
    .raddr (row_r),
    .rdata (ram_rdata)
  );

  // Columns 0 to value_bound take part in the walk.
  always_comb begin
    for (int k = 0; k < COLS; k++) begin
      col_mask[k] = (k <= int'(vb_r));
    end
  end

  // One row step: double the distance and add a random bit, then find the set
  // column whose prefix count of set bits equals the distance; if none, take the
  // row's count of set bits off the distance. A new sample clears the walk state.
  always_comb begin
    row_m = ram_rdata & col_mask;
    dist_dbl = {dist_r[ROWS-2:0], rnd_r[pipe_row_r]};
    pc = CNT_W'($countones(row_m));
    hc = '0;
    for (int k = 0; k < COLS; k++) begin
      cnt_before[k] = CNT_W'($countones(row_m & ({COLS{1'b1}} >> (COLS - k))));
      sel[k] = row_m[k] && (dist_dbl == ROWS'(cnt_before[k]));
      hc = hc | (sel[k] ? CW'(k) : CW'(0));
    end
    dist_nxt = dist_r;
    hit_nxt = hit_r;
    hitcol_nxt = hitcol_r;
    if (accept && (in_data.opcode == OP_SAMPLE)) begin
      dist_nxt = '0;
      hit_nxt = 1'b0;
      hitcol_nxt = '0;
    end else if (pipe_v_r && !hit_r) begin
      if (|sel) begin
        hit_nxt = 1'b1;
        hitcol_nxt = hc;
      end else begin
        dist_nxt = dist_dbl - ROWS'(pc);
      end
    end
  end

  // Signed result: (column - bound + center), negated for a set sign bit.
  always_comb begin
    val_w = $signed(12'(hitcol_r)) - $signed(12'(vb_r)) + 12'(center_r);
    val_s = sign_r ? -val_w : val_w;
  end

  // Sequencer, configuration registers and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pipe_v_r <= 1'b0;
      out_valid_r <= 1'b0;
      vb_r <= VB_RST;
      center_r <= CENTER_RST;
      nrows_cfg_r <= NROWS_RST;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_VALUE_BOUND:   vb_r <= cfg_wdata[VB_W-1:0];
          REG_CENTER_OFFSET: center_r <= $signed(cfg_wdata[CENTER_W-1:0]);
          REG_ROWS_IN_USE:   nrows_cfg_r <= cfg_wdata[NROWS_W-1:0];
          default: ;
        endcase
      end

      // The output register fills when a result is done and empties when taken.
      if ((state_r == S_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      pipe_v_r <= ram_re;
      pipe_row_r <= row_r;
      dist_r <= dist_nxt;
      hit_r <= hit_nxt;
      hitcol_r <= hitcol_nxt;

      unique case (state_r)
        S_IDLE: begin
          if (accept && (in_data.opcode == OP_SAMPLE)) begin
            rnd_r <= in_data.random_bits;
            sign_r <= in_data.sign_bit;
            row_r <= '0;
            state_r <= (nrows == '0) ? S_DONE : S_READ;
          end
        end
        S_READ: begin
          row_r <= row_r + RW'(1);
          if (last_row) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_data_r.sample_value <= val_s[SAMPLE_W-1:0];
            out_data_r.column_found <= hit_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

@@ sv/kyg_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module kyg_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/kyg_checker.sv @@
// Port-level checker of the Gaussian sampler and its bind to the top level.
module kyg_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input kyg_pkg::in_beat_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input kyg_pkg::out_beat_t out_data
);
  import kyg_pkg::*;

  // A stalled result beat stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed or dropped while stalled");

  // A load beat never produces a result.
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && in_valid && in_ready && (in_data.opcode == OP_LOAD) |=> !out_valid)
    else $error("load beat produced a result");

  // A sample closes the input in the cycle after acceptance, and no result rises then.
  a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.opcode == OP_SAMPLE) |=> !in_ready && !$rose(out_valid))
    else $error("sample beat did not hold off the input");

  // A new result appears only at the end of a sample walk.
  a_result_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while the sampler was idle");

endmodule

bind knuth_yao_gaussian_sampler kyg_checker u_kyg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
